// ===== rtl/core/minmax_scalar_quantizer_top_assert.svh =====
// Assertion macros for the min/max scalar quantizer top level.
// Expects clk and rst_n in the scope of each use.
`ifndef MINMAX_SCALAR_QUANTIZER_TOP_ASSERT_SVH
`define MINMAX_SCALAR_QUANTIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MMSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MMSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mmsq_pkg.sv =====
// Shared types and codes of the min/max scalar quantizer.
// No dependencies; used by the controller, the datapath and the top level.
package mmsq_pkg;

  localparam int XW     = 32;
  localparam int CORR_W = 48;
  localparam int CFG_AW = 2;

  // Input actions
  localparam logic [1:0] ACT_TRAIN  = 2'd0;
  localparam logic [1:0] ACT_FINAL  = 2'd1;
  localparam logic [1:0] ACT_ENCODE = 2'd2;

  // Quantizer modes
  localparam logic [1:0] MODE_Q8     = 2'd0;
  localparam logic [1:0] MODE_Q4     = 2'd1;
  localparam logic [1:0] MODE_B_TH   = 2'd2;
  localparam logic [1:0] MODE_B_SIGN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RSRC  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PMIN  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_PMAX  = 2'd3;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_CORR = 1'b1;

  typedef struct packed {
    logic [1:0]           action;
    logic signed [XW-1:0] element;
    logic                 vec_last;
  } in_req_t;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               code_byte;
    logic signed [CORR_W-1:0] correction;
    logic                     run_last;
  } out_res_t;

  typedef enum logic [1:0] {
    MSEL_ENC = 2'd0,
    MSEL_C1  = 2'd1,
    MSEL_C2  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     train;
    logic     finalize;
    logic     div_start;
    logic     div_alpha;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     enc_update;
    logic     emit_byte;
    logic     byte_last;
    logic     emit_corr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic one_bit_sign;
    logic corr_mode;
    logic byte_req;
    logic item_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/minmax_scalar_quantizer_top.sv =====
// Top level of the min/max scalar quantizer.
// Depends on mmsq_pkg, mmsq_ctrl, mmsq_dp and the assertion macro header.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_req  (in_req_t)
//   out_     output     out_valid / out_stall out_res (out_res_t)
//   cfg_     input      cfg_we                cfg_addr, cfg_wdata
//
// Train updates the range as it is taken. Finalize runs the bit-serial divider
// twice (reciprocal, then alpha), NW = max(RECIP_BITS+1, 35) bits, one bit per cycle.
// Encode runs one multiply (none in sign-bit mode), NDIG = 4 digits of 16 bits;
// a last element in an 8-/4-bit mode adds two more multiplies for the correction.
// Reset is synchronous and active low; no clearing pass is needed.
// A result waits in the output register under out_stall; the next item is still taken.
`include "minmax_scalar_quantizer_top_assert.svh"

module minmax_scalar_quantizer_top import mmsq_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int RECIP_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [XW-1:0]     cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_res_t          out_res
);

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_accept;

  // Take a request only while the sequencer is idle
  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;

  mmsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_action (in_req.action),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  mmsq_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .RECIP_BITS (RECIP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Correction results close their request and carry no code byte
  `MMSQ_ASSERT_IMP(a_corr_shape, out_valid && out_res.kind == KIND_CORR, out_res.run_last && out_res.code_byte == 8'd0, "correction result malformed")
  // Encode and finalize keep the input stalled while they run
  `MMSQ_ASSERT_NXT(a_enc_busy, in_accept && in_req.action == ACT_ENCODE, in_stall, "input taken during encode")
  `MMSQ_ASSERT_NXT(a_fin_busy, in_accept && in_req.action == ACT_FINAL, in_stall, "input taken during finalize")

endmodule

// ===== rtl/core/mmsq_ctrl.sv =====
// Sequencer of the min/max scalar quantizer.
// Depends on mmsq_pkg; drives the datapath through cmd_t, reads sts_t.
module mmsq_ctrl import mmsq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [1:0] in_action,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       idle
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_FIN    = 14'b00000000000010,
    S_DIVR   = 14'b00000000000100,
    S_ASTART = 14'b00000000001000,
    S_DIVA   = 14'b00000000010000,
    S_ESTART = 14'b00000000100000,
    S_EMUL   = 14'b00000001000000,
    S_EUPD   = 14'b00000010000000,
    S_EMITB  = 14'b00000100000000,
    S_C1     = 14'b00001000000000,
    S_C1W    = 14'b00010000000000,
    S_C2     = 14'b00100000000000,
    S_C2W    = 14'b01000000000000,
    S_EMITC  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  // Advance the sequence and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd.capture = 1'b1;
          case (in_action)
            ACT_TRAIN: cmd.train = 1'b1;
            ACT_FINAL: begin
              cmd.finalize = 1'b1;
              state_nxt    = S_FIN;
            end
            ACT_ENCODE: state_nxt = S_ESTART;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIN: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVR;
      end
      S_DIVR: begin
        if (sts.div_done) state_nxt = S_ASTART;
      end
      S_ASTART: begin
        cmd.div_start = 1'b1;
        cmd.div_alpha = 1'b1;
        state_nxt     = S_DIVA;
      end
      S_DIVA: begin
        if (sts.div_done) state_nxt = S_IDLE;
      end
      S_ESTART: begin
        if (sts.one_bit_sign) begin
          state_nxt = S_EUPD;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_ENC;
          state_nxt     = S_EMUL;
        end
      end
      S_EMUL: begin
        if (sts.mul_done) state_nxt = S_EUPD;
      end
      S_EUPD: begin
        cmd.enc_update = 1'b1;
        state_nxt      = sts.byte_req ? S_EMITB : S_IDLE;
      end
      S_EMITB: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          cmd.byte_last = !(sts.item_last && sts.corr_mode);
          state_nxt     = (sts.item_last && sts.corr_mode) ? S_C1 : S_IDLE;
        end
      end
      S_C1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_C1;
        state_nxt     = S_C1W;
      end
      S_C1W: begin
        if (sts.mul_done) state_nxt = S_C2;
      end
      S_C2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_C2;
        state_nxt     = S_C2W;
      end
      S_C2W: begin
        if (sts.mul_done) state_nxt = S_EMITC;
      end
      S_EMITC: begin
        if (sts.out_free) begin
          cmd.emit_corr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/mmsq_dp.sv =====
// Datapath of the min/max scalar quantizer: registers, range tracking,
// bit-serial divider, digit-serial multiplier, packing, output register.
// Depends on mmsq_pkg; commanded by mmsq_ctrl.
module mmsq_dp import mmsq_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int RECIP_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [XW-1:0]     cfg_wdata,
  input  in_req_t           in_req,
  input  cmd_t              cmd,
  input  logic              out_stall,
  output sts_t              sts,
  output logic              out_valid,
  output out_res_t          out_res
);

  localparam int RB   = RECIP_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int VW   = XW + 1;
  localparam int AW   = VW + 8;
  localparam int BW   = (RB > 64) ? RB : 64;
  localparam int DIG  = 16;
  localparam int NDIG = (BW + DIG - 1) / DIG;
  localparam int BPW  = NDIG * DIG;
  localparam int PW   = AW + BPW;
  localparam int MCW  = $clog2(NDIG + 1);
  localparam int RW   = VW + 2;
  localparam int NW   = (RB + 1 > RW) ? RB + 1 : RW;
  localparam int DCW  = $clog2(NW + 1);
  localparam int CDW  = AW + 2;
  localparam int QRW  = PW - RB + 1;
  localparam int QFW  = PW - FB + 1;
  localparam logic [PW:0] HALF_R = {{PW{1'b0}}, 1'b1} << (RB - 1);
  localparam logic [PW:0] HALF_F = {{PW{1'b0}}, 1'b1} << (FB - 1);
  localparam logic [NW-1:0] RCAP = {{(NW - RB){1'b0}}, {RB{1'b1}}};
  localparam logic signed [CDW:0] SUM_MAX = (CDW + 1)'(64'sd2147483647);
  localparam logic signed [CDW:0] SUM_MIN = (CDW + 1)'(-64'sd2147483648);

  // Configuration and range state
  logic [1:0]           mode_r;
  logic                 rsrc_r;
  logic signed [XW-1:0] pmin_r, pmax_r, tmin_r, tmax_r, wmin_r;
  logic signed [VW-1:0] diff_r;
  logic [RB-1:0]        recip_r;
  logic [VW-1:0]        alpha_r;
  logic signed [XW-1:0] sum_r;
  logic [7:0]           pack_r, hold_r;
  logic [2:0]           pcnt_r;
  logic signed [XW-1:0] x_r;
  logic                 last_r;

  // Divider and multiplier state
  logic           dbusy_r, dsel_r;
  logic [DCW-1:0] dcnt_r;
  logic [NW-1:0]  dnum_r;
  logic [RW-1:0]  drem_r, ddiv_r;
  logic           mbusy_r;
  logic [MCW-1:0] mcnt_r;
  logic [AW-1:0]  ma_r;
  logic [BPW-1:0] mb_r;
  logic [PW-1:0]  prod_r;

  logic     out_valid_r;
  out_res_t out_res_r;

  // Range latch at finalize
  logic signed [XW-1:0] mn_c, mx_c;
  logic signed [VW-1:0] diff_c;
  logic [VW-1:0]        ad_c;
  logic [8:0]           s_c;
  logic                 corr_mode;

  assign mn_c      = rsrc_r ? pmin_r : tmin_r;
  assign mx_c      = rsrc_r ? pmax_r : tmax_r;
  assign diff_c    = {mx_c[XW-1], mx_c} - {mn_c[XW-1], mn_c};
  assign ad_c      = diff_r[VW-1] ? VW'(-diff_r) : VW'(diff_r);
  assign s_c       = (mode_r == MODE_Q4) ? 9'd15 : 9'd255;
  assign corr_mode = (mode_r == MODE_Q8) || (mode_r == MODE_Q4);

  // Divider step: one quotient bit per cycle
  logic [RW-1:0] dshift, drem_nxt;
  logic          dge;
  logic [NW-1:0] dnum_nxt;
  logic          ddone;
  logic [RW-1:0] alnum;

  assign dshift   = {drem_r[RW-2:0], dnum_r[NW-1]};
  assign dge      = dshift >= ddiv_r;
  assign drem_nxt = dge ? dshift - ddiv_r : dshift;
  assign dnum_nxt = {dnum_r[NW-2:0], dge};
  assign ddone    = dbusy_r && (dcnt_r == DCW'(1));
  assign alnum    = {1'b0, ad_c, 1'b0} + RW'(s_c);

  // Encode operands
  logic signed [VW-1:0] v_c;
  logic [VW-1:0]        av_c;
  logic                 neg_c;
  logic [AW-1:0]        sav_c;
  logic [XW-1:0]        msum_c, mwmin_c;

  assign v_c     = {x_r[XW-1], x_r} - {wmin_r[XW-1], wmin_r};
  assign av_c    = v_c[VW-1] ? VW'(-v_c) : VW'(v_c);
  assign neg_c   = v_c[VW-1] ^ diff_r[VW-1];
  assign sav_c   = (mode_r == MODE_Q4) ? (AW'({av_c, 4'b0}) - AW'(av_c))
                                       : (AW'({av_c, 8'b0}) - AW'(av_c));
  assign msum_c  = sum_r[XW-1] ? XW'(-sum_r) : XW'(sum_r);
  assign mwmin_c = wmin_r[XW-1] ? XW'(-wmin_r) : XW'(wmin_r);

  // Multiplier step: one 16-bit digit of B per cycle, MSB first
  logic [DIG-1:0]    digit;
  logic [AW+DIG-1:0] pp;
  logic [PW-1:0]     prod_nxt;
  logic              mdone;
  logic [AW-1:0]     ma_c;
  logic [BPW-1:0]    mb_c;

  assign digit    = mb_r[BPW-1 -: DIG];
  assign pp       = ma_r * digit;
  assign prod_nxt = {prod_r[PW-DIG-1:0], {DIG{1'b0}}} + PW'(pp);
  assign mdone    = mbusy_r && (mcnt_r == MCW'(1));

  always_comb begin
    case (cmd.mul_sel)
      MSEL_ENC: begin
        ma_c = corr_mode ? sav_c : AW'(av_c);
        mb_c = BPW'(recip_r);
      end
      MSEL_C1: begin
        ma_c = AW'(msum_c);
        mb_c = BPW'(mwmin_c);
      end
      MSEL_C2: begin
        ma_c = AW'(alpha_r);
        mb_c = BPW'(prod_r[63:0]);
      end
      default: begin
        ma_c = '0;
        mb_c = '0;
      end
    endcase
  end

  // Code, running sum and packing
  logic [PW:0]           rnd_r;
  logic [QRW-1:0]        qr;
  logic signed [CDW-1:0] qmag, code;
  logic signed [CDW:0]   sum_ext;
  logic signed [XW-1:0]  sum_new;
  logic [7:0]            clamp;
  logic                  bit_c, full_c;
  logic [7:0]            pnew;

  assign rnd_r   = {1'b0, prod_r} + HALF_R;
  assign qr      = rnd_r[PW:RB];
  assign qmag    = {1'b0, qr[CDW-2:0]};
  assign code    = neg_c ? -qmag : qmag;
  assign sum_ext = {{(CDW + 1 - XW){sum_r[XW-1]}}, sum_r} + {code[CDW-1], code};

  always_comb begin
    if (sum_ext > SUM_MAX)      sum_new = SUM_MAX[XW-1:0];
    else if (sum_ext < SUM_MIN) sum_new = SUM_MIN[XW-1:0];
    else                        sum_new = sum_ext[XW-1:0];
    if (code[CDW-1])                  clamp = 8'd0;
    else if (qmag > CDW'(s_c))        clamp = s_c[7:0];
    else                              clamp = qmag[7:0];
  end

  always_comb begin
    bit_c  = 1'b0;
    pnew   = pack_r;
    full_c = 1'b0;
    case (mode_r)
      MODE_Q8: begin
        pnew   = clamp;
        full_c = 1'b1;
      end
      MODE_Q4: begin
        pnew   = pack_r | (pcnt_r[0] ? {clamp[3:0], 4'b0} : {4'b0, clamp[3:0]});
        full_c = pcnt_r[0];
      end
      MODE_B_TH: begin
        bit_c  = !neg_c && (v_c != '0) && ({1'b0, prod_r} > HALF_R);
        pnew   = pack_r | (8'(bit_c) << pcnt_r);
        full_c = (pcnt_r == 3'd7);
      end
      MODE_B_SIGN: begin
        bit_c  = (x_r > 0);
        pnew   = pack_r | (8'(bit_c) << pcnt_r);
        full_c = (pcnt_r == 3'd7);
      end
      default: pnew = pack_r;
    endcase
  end

  // Correction: round, saturate and negate the product
  logic [PW:0]         rnd_f;
  logic [QFW-1:0]      qf;
  logic                prod_neg;
  logic [CORR_W-1:0]   lim, qsat, corr_c;

  assign rnd_f    = {1'b0, prod_r} + HALF_F;
  assign qf       = rnd_f[PW:FB];
  assign prod_neg = sum_r[XW-1] ^ wmin_r[XW-1] ^ (diff_r[VW-1] && (alpha_r != '0));
  assign lim      = prod_neg ? {1'b0, {(CORR_W - 1){1'b1}}} : {1'b1, {(CORR_W - 1){1'b0}}};
  assign qsat     = (qf > QFW'(lim)) ? lim : qf[CORR_W-1:0];
  assign corr_c   = prod_neg ? qsat : CORR_W'(-qsat);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration, range and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_Q8;
      rsrc_r  <= 1'b0;
      pmin_r  <= '0;
      pmax_r  <= '0;
      tmin_r  <= {1'b0, {(XW - 1){1'b1}}};
      tmax_r  <= {1'b1, {(XW - 1){1'b0}}};
      wmin_r  <= '0;
      diff_r  <= '0;
      recip_r <= '0;
      alpha_r <= '0;
      sum_r   <= '0;
      pack_r  <= '0;
      pcnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE: mode_r <= cfg_wdata[1:0];
          REG_RSRC: rsrc_r <= cfg_wdata[0];
          REG_PMIN: pmin_r <= cfg_wdata;
          REG_PMAX: pmax_r <= cfg_wdata;
          default:  mode_r <= mode_r;
        endcase
      end
      if (cmd.train) begin
        if (in_req.element < tmin_r) tmin_r <= in_req.element;
        if (in_req.element > tmax_r) tmax_r <= in_req.element;
      end
      if (cmd.finalize) begin
        wmin_r <= mn_c;
        diff_r <= diff_c;
        sum_r  <= '0;
        pack_r <= '0;
        pcnt_r <= '0;
      end
      if (ddone) begin
        if (dsel_r)             alpha_r <= dnum_nxt[VW-1:0];
        else if (ad_c == '0)    recip_r <= '0;
        else if (dnum_nxt > RCAP) recip_r <= RCAP[RB-1:0];
        else                    recip_r <= dnum_nxt[RB-1:0];
      end
      if (cmd.enc_update) begin
        if (corr_mode) sum_r <= sum_new;
        if (full_c || last_r) begin
          pack_r <= '0;
          pcnt_r <= '0;
        end else begin
          pack_r <= pnew;
          pcnt_r <= pcnt_r + 3'd1;
        end
      end
      // Drop the sum once the final result of a vector goes out
      if ((cmd.emit_byte && cmd.byte_last && last_r) || cmd.emit_corr) sum_r <= '0;
    end
  end

  // Hold the item and the byte to emit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r    <= in_req.element;
      last_r <= in_req.vec_last;
    end
    if (cmd.enc_update) hold_r <= pnew;
  end

  // Divider control and data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= DCW'(NW);
    end else if (dbusy_r) begin
      dbusy_r <= !ddone;
      dcnt_r  <= dcnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= cmd.div_alpha;
      drem_r <= '0;
      if (cmd.div_alpha) begin
        dnum_r <= NW'(alnum);
        ddiv_r <= RW'({s_c, 1'b0});
      end else begin
        dnum_r <= {{(NW - 1){1'b0}}, 1'b1} << RB;
        ddiv_r <= RW'(ad_c);
      end
    end else if (dbusy_r) begin
      drem_r <= drem_nxt;
      dnum_r <= dnum_nxt;
    end
  end

  // Multiplier control and data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= MCW'(NDIG);
    end else if (mbusy_r) begin
      mbusy_r <= !mdone;
      mcnt_r  <= mcnt_r - MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r   <= ma_c;
      mb_r   <= mb_c;
      prod_r <= '0;
    end else if (mbusy_r) begin
      mb_r   <= {mb_r[BPW-DIG-1:0], {DIG{1'b0}}};
      prod_r <= prod_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)                                 out_valid_r <= 1'b0;
    else if (cmd.emit_byte || cmd.emit_corr)    out_valid_r <= 1'b1;
    else if (!out_stall)                        out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_res_r.kind       <= KIND_BYTE;
      out_res_r.code_byte  <= hold_r;
      out_res_r.correction <= '0;
      out_res_r.run_last   <= cmd.byte_last;
    end else if (cmd.emit_corr) begin
      out_res_r.kind       <= KIND_CORR;
      out_res_r.code_byte  <= 8'd0;
      out_res_r.correction <= corr_c;
      out_res_r.run_last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign sts.div_done     = ddone;
  assign sts.mul_done     = mdone;
  assign sts.one_bit_sign = (mode_r == MODE_B_SIGN);
  assign sts.corr_mode    = corr_mode;
  assign sts.byte_req     = full_c || last_r;
  assign sts.item_last    = last_r;
  assign sts.out_free     = out_free;

endmodule

// ===== dv/mmsq_checker.sv =====
// Checker for the min/max scalar quantizer: watches config, request and result channels.
// Predicts each result from its own copy of the state and compares it in order.
// Depends on mmsq_pkg.
`timescale 1ns / 100ps

module mmsq_checker import mmsq_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int RECIP_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [XW-1:0]     cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_req_t           in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_res_t          out_res,
  output int                fail_count,
  output int                pending
);

  // Mirrored configuration
  logic [1:0] q_mode;
  logic       q_rsrc;
  longint     q_pmin, q_pmax;

  // Mirrored quantizer state
  longint     tr_min, tr_max, work_min, rng_diff, alpha, code_sum;
  logic [63:0] recip;
  logic [7:0] pack_byte;
  logic [2:0] pack_cnt;

  out_res_t   expected_codes[$];

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Correction -sum*min*alpha, rounded and saturated to 48 bits
  function automatic logic [47:0] sum_correction();
    logic [127:0] p, q;
    logic [63:0]  lim;
    logic [63:0]  r;
    logic         pneg;
    pneg = ((code_sum < 0) != (work_min < 0)) != (alpha < 0);
    p = 128'(mag(code_sum) * mag(work_min)) * 128'(mag(alpha));
    q = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = pneg ? (64'd1 << 47) - 1 : (64'd1 << 47);
    r = q[63:0];
    if (q[127:64] != 0 || r > lim) r = lim;
    r = pneg ? r : -r;
    return r[47:0];
  endfunction

  // Advance the mirrored state by one request and queue the results it causes
  task automatic quantize_step(in_req_t r);
    longint       x, v, mn, mx, code, clamped;
    logic [63:0]  av, ad, s;
    logic [127:0] p, q;
    logic         neg, full, bitv;
    out_res_t     res[2];
    int           n;
    x = longint'(r.element);
    n = 0;
    full = 0;
    case (r.action)
      ACT_TRAIN: begin
        if (x < tr_min) tr_min = x;
        if (x > tr_max) tr_max = x;
      end
      ACT_FINAL: begin
        mn = q_rsrc ? q_pmin : tr_min;
        mx = q_rsrc ? q_pmax : tr_max;
        s = (q_mode == MODE_Q4) ? 15 : 255;
        work_min = mn;
        rng_diff = mx - mn;
        ad = mag(rng_diff);
        if (ad == 0) recip = 0;
        else begin
          recip = (64'd1 << RECIP_BITS) / ad;
          if (recip > (64'd1 << RECIP_BITS) - 1) recip = (64'd1 << RECIP_BITS) - 1;
        end
        alpha = longint'((2 * ad + s) / (2 * s));
        if (rng_diff < 0) alpha = -alpha;
        code_sum = 0;
        pack_byte = 0;
        pack_cnt = 0;
      end
      ACT_ENCODE: begin
        v = x - work_min;
        av = mag(v);
        neg = (v < 0) != (rng_diff < 0);
        if (q_mode == MODE_Q8 || q_mode == MODE_Q4) begin
          s = (q_mode == MODE_Q8) ? 255 : 15;
          p = 128'(s * av) * 128'(recip);
          q = (p + (128'd1 << (RECIP_BITS - 1))) >> RECIP_BITS;
          code = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
          clamped = (code < 0) ? 0 : ((code > longint'(s)) ? longint'(s) : code);
          code_sum += code;
          if (code_sum > 64'sd2147483647) code_sum = 64'sd2147483647;
          if (code_sum < -64'sd2147483648) code_sum = -64'sd2147483648;
          if (q_mode == MODE_Q8) begin
            pack_byte = 8'(clamped);
            full = 1;
          end else begin
            pack_byte |= 8'(clamped) << (pack_cnt[0] * 4);
            full = pack_cnt[0];
          end
        end else begin
          if (q_mode == MODE_B_TH) begin
            p = 128'(av) * 128'(recip);
            bitv = !neg && v != 0 && p > (128'd1 << (RECIP_BITS - 1));
          end else bitv = x > 0;
          if (bitv) pack_byte |= 8'd1 << pack_cnt;
          full = (pack_cnt == 3'd7);
        end
        pack_cnt = pack_cnt + 3'd1;
        if (full || r.vec_last) begin
          res[n] = '{kind: KIND_BYTE, code_byte: pack_byte, correction: '0, run_last: 1'b0};
          n++;
          pack_byte = 0;
          pack_cnt = 0;
        end
        if (r.vec_last) begin
          if (q_mode == MODE_Q8 || q_mode == MODE_Q4) begin
            res[n] = '{kind: KIND_CORR, code_byte: 8'd0, correction: sum_correction(),
                       run_last: 1'b0};
            n++;
          end
          code_sum = 0;
        end
        if (n > 0) res[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++) expected_codes.push_back(res[i]);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      q_mode = MODE_Q8; q_rsrc = 0; q_pmin = 0; q_pmax = 0;
      tr_min = 64'sd2147483647; tr_max = -64'sd2147483648;
      work_min = 0; rng_diff = 0; recip = 0; alpha = 0; code_sum = 0;
      pack_byte = 0; pack_cnt = 0;
      expected_codes.delete();
      fail_count = 0;
    end else begin
      // Apply register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE: q_mode = cfg_wdata[1:0];
          REG_RSRC: q_rsrc = cfg_wdata[0];
          REG_PMIN: q_pmin = longint'($signed(cfg_wdata));
          REG_PMAX: q_pmax = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      // Compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected result %p", $realtime, out_res);
        end else begin
          e = expected_codes.pop_front();
          if (out_res.kind !== e.kind || out_res.code_byte !== e.code_byte ||
              out_res.correction !== e.correction || out_res.run_last !== e.run_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch kind %0d/%0d byte %h/%h corr %0d/%0d last %0d/%0d",
                       $realtime, e.kind, out_res.kind, e.code_byte, out_res.code_byte,
                       e.correction, out_res.correction, e.run_last, out_res.run_last);
          end
        end
      end
      // Predict an accepted request
      if (in_valid && !in_stall) quantize_step(in_req);
    end
    pending = expected_codes.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the min/max scalar quantizer: clock, reset, stimulus and verdict.
// Depends on mmsq_pkg, minmax_scalar_quantizer_top and mmsq_checker.
`timescale 1ns / 100ps

module tb;
  import mmsq_pkg::*;

  localparam int SETTLE = 120;
  localparam int WD_LIMIT = 5000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [XW-1:0]     cfg_wdata = '0;
  logic              in_valid = 0;
  logic              in_stall;
  in_req_t           in_req = '0;
  logic              out_valid;
  logic              out_stall = 0;
  out_res_t          out_res;
  int                fail_count, pending;
  logic              hold_req = 0;
  logic              quiet = 0;
  int                idle_cycles = 0;

  always #1 clk = ~clk;

  minmax_scalar_quantizer_top u_dut (.*);

  mmsq_checker u_chk (.*);

  // Receiver: random stalls, a long hold-off on request
  always @(posedge clk) begin
    int run, hold_left, r;
    if (hold_req) hold_left = 600;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (run > 0) begin
      run--;
      out_stall <= 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 70) out_stall <= 0;
      else begin
        out_stall <= 1;
        run = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("minmax_scalar_quantizer_top regression: fail");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [31:0] elem, logic last);
    int g, r;
    r = $urandom_range(0, 99);
    g = (quiet || r < 60) ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 30));
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_req <= '{action: act, element: elem, vec_last: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wr(logic [CFG_AW-1:0] a, logic [31:0] d);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // Drop the request, wait for every result, then let the block go idle
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic rs, logic [31:0] pmin, logic [31:0] pmax);
    settle();
    wr(REG_MODE, {30'd0, m});
    wr(REG_RSRC, {31'd0, rs});
    wr(REG_PMIN, pmin);
    wr(REG_PMAX, pmax);
    cfg_we <= 0;
  endtask

  // Element mostly inside [lo, hi], sometimes anywhere
  function automatic logic [31:0] pick_elem(longint lo, longint hi);
    int r;
    longint a, b, w;
    r = $urandom_range(0, 99);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    w = b - a + 1;
    if (r < 80) return 32'(a + longint'({$urandom, $urandom}) % w);
    if (r < 90) return 32'(a + $signed($urandom_range(0, 2000)) - 1000);
    return $urandom;
  endfunction

  task automatic run_vectors(int count, longint lo, longint hi);
    int len;
    while (count > 0) begin
      len = $urandom_range(0, 9) < 8 ? $urandom_range(1, 12) : $urandom_range(13, 40);
      for (int i = 0; i < len && count > 0; i++, count--) begin
        if ($urandom_range(0, 49) == 0) send(2'd3, $urandom, $urandom_range(0, 1));
        send(ACT_ENCODE, pick_elem(lo, hi), (i == len - 1) || count == 1);
      end
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic        rs;
    longint      pmin, pmax, t;
    int          r;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: encode before finalize, finalize with no training, action 3
    send(ACT_ENCODE, 32'h0005_0000, 1);
    send(ACT_FINAL, 32'hFFFF_FFFF, 1);
    send(ACT_ENCODE, 32'h8000_0000, 0);
    send(ACT_ENCODE, 32'h7FFF_FFFF, 1);
    send(2'd3, 32'h1234_5678, 1);
    // Trained range, 8-bit codes at the extremes and midpoint
    send(ACT_TRAIN, 32'hFFFE_0000, 0);
    send(ACT_TRAIN, 32'h0003_0000, 1);
    send(ACT_FINAL, 32'h0, 0);
    send(ACT_ENCODE, 32'hFFFE_0000, 0);
    send(ACT_ENCODE, 32'h0003_0000, 0);
    send(ACT_ENCODE, 32'h0000_8000, 0);
    send(ACT_ENCODE, 32'h7FFF_FFFF, 0);
    send(ACT_ENCODE, 32'h8000_0000, 1);
    // Four-bit packing with an odd count, then zero range preset
    configure(MODE_Q4, 1, 32'hFFFF_0000, 32'h0001_0000);
    send(ACT_FINAL, 32'h0, 0);
    send(ACT_ENCODE, 32'hFFFF_0000, 0);
    send(ACT_ENCODE, 32'h0001_0000, 0);
    send(ACT_ENCODE, 32'h0000_0000, 1);
    configure(MODE_B_TH, 1, 32'h0000_1000, 32'h0000_1000);
    send(ACT_FINAL, 32'h0, 0);
    send(ACT_ENCODE, 32'h0000_2000, 1);
    // Sign bits, reversed preset range
    configure(MODE_B_SIGN, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send(ACT_FINAL, 32'h0, 0);
    for (int i = 0; i < 9; i++) send(ACT_ENCODE, $urandom, i == 8);

    // Random phases
    for (int ph = 0; ph < 16; ph++) begin
      m = $urandom_range(0, 3);
      rs = $urandom_range(0, 1);
      r = $urandom_range(0, 4);
      case (r)
        0: begin pmin = $signed($urandom_range(0, 2000000)) - 1000000;
                 pmax = pmin + $urandom_range(1, 3000000); end
        1: begin pmin = longint'($signed($urandom)); pmax = longint'($signed($urandom)); end
        2: begin pmin = longint'($signed($urandom)); pmax = pmin; end
        3: begin pmin = -64'sd2147483648; pmax = 64'sd2147483647; end
        default: begin pmin = 64'sd2147483647; pmax = -64'sd2147483648; end
      endcase
      if (ph == 15) begin
        m = MODE_Q8;
        rs = 0;
      end
      configure(m, rs, 32'(pmin), 32'(pmax));
      quiet <= (ph % 5 == 2);
      // Training; the full-scale extremes only in the last phase
      for (int i = 0; i < $urandom_range(1, 6); i++) begin
        t = $signed($urandom_range(0, 400000)) - 200000 - ph * 50000;
        send(ACT_TRAIN, 32'(t), $urandom_range(0, 1));
      end
      if (ph == 15) begin
        send(ACT_TRAIN, 32'h8000_0000, 0);
        send(ACT_TRAIN, 32'h7FFF_FFFF, 0);
      end
      send(ACT_FINAL, $urandom, $urandom_range(0, 1));
      if (!rs) begin pmin = u_chk.tr_min; pmax = u_chk.tr_max; end
      if (ph == 3) begin
        // Hold off the receiver while requests keep coming
        hold_req <= 1;
        @(posedge clk);
        hold_req <= 0;
      end
      run_vectors(55, pmin, pmax);
      if ($urandom_range(0, 1)) send(ACT_FINAL, $urandom, 0);
      run_vectors(55, pmin, pmax);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("minmax_scalar_quantizer_top regression: pass");
    else
      $display("minmax_scalar_quantizer_top regression: fail");
    $finish;
  end

endmodule
